// ----- src/gles_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// gles_pkg
// Shared constants, codes and interface types of the gate-level event
// simulator: table geometry, command and logic codes, gate types and the
// structs that pass between the sequencer and the table store.
// ----------------------------------------------------------------------------
package gles_pkg;

    localparam int NUM_GATES  = 1024;
    localparam int NUM_EDGES  = 4096;
    localparam int MAX_FANOUT = 16;

    localparam int GATE_AW  = $clog2(NUM_GATES);
    localparam int OFF_AW   = $clog2(NUM_GATES + 1);
    localparam int EDGE_AW  = $clog2(NUM_EDGES);
    localparam int GSTATE_W = 26;
    localparam int OFF_W    = 13;
    localparam int EDGE_W   = 11;
    localparam int DELAY_W  = 16;
    localparam int CNT_W    = $clog2(MAX_FANOUT + 1);

    typedef enum logic [1:0] {
        CMD_EVENT     = 2'd0,
        CMD_WR_GATE   = 2'd1,
        CMD_WR_OFFSET = 2'd2,
        CMD_WR_EDGE   = 2'd3
    } cmd_t;

    localparam logic [1:0] LV_0    = 2'd0;
    localparam logic [1:0] LV_1    = 2'd1;
    localparam logic [1:0] LOGIC_X = 2'd2;
    localparam logic [1:0] LOGIC_Z = 2'd3;

    typedef enum logic [2:0] {
        GT_BUF  = 3'd0,
        GT_INV  = 3'd1,
        GT_NAND = 3'd2,
        GT_NOR  = 3'd3,
        GT_AND  = 3'd4,
        GT_OR   = 3'd5,
        GT_XOR  = 3'd6,
        GT_XNOR = 3'd7
    } gate_type_t;

    typedef struct packed {
        logic                gate_we;
        logic [GATE_AW-1:0]  gate_waddr;
        logic [GSTATE_W-1:0] gate_wdata;
        logic                gate_re;
        logic [GATE_AW-1:0]  gate_raddr;
        logic                off_we;
        logic [OFF_AW-1:0]   off_waddr;
        logic [OFF_W-1:0]    off_wdata;
        logic                off_re;
        logic [OFF_AW-1:0]   off_raddr;
        logic                edge_we;
        logic [EDGE_AW-1:0]  edge_waddr;
        logic [EDGE_W-1:0]   edge_wdata;
        logic                edge_re;
        logic [EDGE_AW-1:0]  edge_raddr;
    } tbl_ctrl_t;

    typedef struct packed {
        logic [GSTATE_W-1:0] gate_word;
        logic [OFF_W-1:0]    off_start;
        logic [OFF_W-1:0]    off_end;
        logic [EDGE_W-1:0]   edge_word;
    } tbl_rd_t;

endpackage
`default_nettype wire

// ----- src/gles_tables.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// gles_tables
// Gate state, fan-out offset and edge memories, each with one write port
// and registered reads. The offset memory reads an entry and its successor
// together so that both ends of a fan-out range arrive together.
// ----------------------------------------------------------------------------
module gles_tables (
    input  wire                        clk,
    input  wire gles_pkg::tbl_ctrl_t   ctrl,
    output gles_pkg::tbl_rd_t          rd
);
    import gles_pkg::*;

    logic [GSTATE_W-1:0] gate_mem [NUM_GATES];
    logic [OFF_W-1:0]    off_mem  [NUM_GATES + 1];
    logic [EDGE_W-1:0]   edge_mem [NUM_EDGES];

    logic [GSTATE_W-1:0] gate_rd_reg;
    logic [OFF_W-1:0]    start_rd_reg;
    logic [OFF_W-1:0]    end_rd_reg;
    logic [EDGE_W-1:0]   edge_rd_reg;
    logic [OFF_AW-1:0]   off_raddr_succ;

    assign off_raddr_succ = ctrl.off_raddr + OFF_AW'(1);

    always_ff @(posedge clk)
    begin
        if (ctrl.gate_we)
        begin
            gate_mem[ctrl.gate_waddr] <= ctrl.gate_wdata;
        end
        if (ctrl.gate_re)
        begin
            gate_rd_reg <= gate_mem[ctrl.gate_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.off_we)
        begin
            off_mem[ctrl.off_waddr] <= ctrl.off_wdata;
        end
        if (ctrl.off_re)
        begin
            start_rd_reg <= off_mem[ctrl.off_raddr];
            end_rd_reg   <= off_mem[off_raddr_succ];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.edge_we)
        begin
            edge_mem[ctrl.edge_waddr] <= ctrl.edge_wdata;
        end
        if (ctrl.edge_re)
        begin
            edge_rd_reg <= edge_mem[ctrl.edge_raddr];
        end
    end

    assign rd.gate_word = gate_rd_reg;
    assign rd.off_start = start_rd_reg;
    assign rd.off_end   = end_rd_reg;
    assign rd.edge_word = edge_rd_reg;

endmodule
`default_nettype wire

// ----- src/gles_alu.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// gles_alu
// Shared 32-bit adder with a compare of the sum against a limit. The
// sequencer uses it for the event time and for stepping the edge index.
// ----------------------------------------------------------------------------
module gles_alu (
    input  wire  [31:0] a,
    input  wire  [31:0] b,
    input  wire  [31:0] limit,
    output logic [31:0] sum,
    output logic        reached
);
    import gles_pkg::*;

    assign sum     = a + b;
    assign reached = (sum >= limit);

endmodule
`default_nettype wire

// ----- src/gles_eval.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// gles_eval
// Four-valued gate evaluation with X propagation. The two-input gates treat
// X and Z alike; a controlling input decides the output, otherwise X.
// ----------------------------------------------------------------------------
module gles_eval (
    input  wire  [1:0]                 in0,
    input  wire  [1:0]                 in1,
    input  wire gles_pkg::gate_type_t  gtype,
    output logic [1:0]                 y
);
    import gles_pkg::*;

    logic a0;
    logic a1;
    logic b0;
    logic b1;
    logic known;

    assign a0    = (in0 == LV_0);
    assign a1    = (in0 == LV_1);
    assign b0    = (in1 == LV_0);
    assign b1    = (in1 == LV_1);
    assign known = (a0 || a1) && (b0 || b1);

    always_comb
    begin
        y = LOGIC_X;
        unique case (gtype)
            GT_BUF:
            begin
                y = in0;
            end
            GT_INV:
            begin
                y = a0 ? LV_1 : (a1 ? LV_0 : in0);
            end
            GT_NAND:
            begin
                y = (a1 && b1) ? LV_0 : ((a0 || b0) ? LV_1 : LOGIC_X);
            end
            GT_NOR:
            begin
                y = (a1 || b1) ? LV_0 : ((a0 && b0) ? LV_1 : LOGIC_X);
            end
            GT_AND:
            begin
                y = (a1 && b1) ? LV_1 : ((a0 || b0) ? LV_0 : LOGIC_X);
            end
            GT_OR:
            begin
                y = (a1 || b1) ? LV_1 : ((a0 && b0) ? LV_0 : LOGIC_X);
            end
            GT_XOR:
            begin
                y = !known ? LOGIC_X : ((a1 != b1) ? LV_1 : LV_0);
            end
            GT_XNOR:
            begin
                y = !known ? LOGIC_X : ((a1 == b1) ? LV_1 : LV_0);
            end
            default:
            begin
                y = LOGIC_X;
            end
        endcase
    end

endmodule
`default_nettype wire

// ----- src/gate_level_event_simulator_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// gate_level_event_simulator_top
// Four-valued gate-level event simulator: table loading, gate
// read-modify-write and fan-out walk under a small sequencer.
// ----------------------------------------------------------------------------
// A table write command is taken and busy stays low. An event command
// holds busy high through the evaluate state and the result beats it
// emits, one per fan-out event (at most 16): the gate state and fan-out
// range are read from their memories at the accepting edge, the evaluate
// state computes the gate and writes it back, then one result beat follows
// per cycle from the edge memory, which is read one entry ahead of the beat
// on the ports. An event whose gate output does not change emits no beat.
// Each result beat is on the ports for exactly one cycle with result_strobe
// high and cannot be held off; last marks the final beat of an event. The
// tables need no clearing after reset, but an entry must be written before
// it is used.
// ----------------------------------------------------------------------------
module gate_level_event_simulator_top (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         start,
    output logic        busy,
    input  wire  [1:0]  command,
    input  wire  [31:0] timestamp,
    input  wire  [9:0]  gate,
    input  wire         port,
    input  wire  [1:0]  logic_value,
    input  wire  [11:0] table_index,
    input  wire  [25:0] table_word,
    output logic        result_strobe,
    output logic [31:0] event_time,
    output logic [9:0]  target_gate,
    output logic        target_port,
    output logic [1:0]  event_value,
    output logic        last
);
    import gles_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_EVAL = 3'b010,
        ST_EMIT = 3'b100
    } state_t;

    state_t             state_reg, state_next;
    logic [31:0]        ts_reg, ts_next;
    logic [GATE_AW-1:0] gate_reg, gate_next;
    logic               port_reg, port_next;
    logic [1:0]         value_reg, value_next;
    logic [31:0]        time_reg, time_next;
    logic [1:0]         nw_reg, nw_next;
    logic [OFF_W-1:0]   idx_reg, idx_next;
    logic [OFF_W-1:0]   end_reg, end_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;

    tbl_ctrl_t          ctrl;
    tbl_rd_t            rd;

    logic               accept;
    cmd_t               cmd;
    logic [1:0]         cur_out;
    logic [1:0]         in0;
    logic [1:0]         in1;
    logic [1:0]         new_out;
    logic [OFF_W-1:0]   end_clip;
    logic [31:0]        alu_a;
    logic [31:0]        alu_b;
    logic [31:0]        alu_limit;
    logic [31:0]        alu_sum;
    logic               alu_reached;
    logic               final_beat;

    assign accept  = start && !busy;
    assign cmd     = cmd_t'(command);
    assign cur_out = rd.gate_word[25:24];
    assign in0     = (port_reg == 1'b0) ? value_reg : rd.gate_word[23:22];
    assign in1     = (port_reg == 1'b1) ? value_reg : rd.gate_word[21:20];

    // The walk never runs past the end of the edge table.
    assign end_clip = (32'(rd.off_end) > NUM_EDGES) ? OFF_W'(NUM_EDGES) : rd.off_end;

    gles_tables u_tables (
        .clk  (clk),
        .ctrl (ctrl),
        .rd   (rd)
    );

    gles_eval u_eval (
        .in0   (in0),
        .in1   (in1),
        .gtype (gate_type_t'(rd.gate_word[18:16])),
        .y     (new_out)
    );

    gles_alu u_alu (
        .a       (alu_a),
        .b       (alu_b),
        .limit   (alu_limit),
        .sum     (alu_sum),
        .reached (alu_reached)
    );

    // Operand selection for the shared adder.
    always_comb
    begin
        if (state_reg == ST_EVAL)
        begin
            alu_a     = ts_reg;
            alu_b     = 32'(rd.gate_word[DELAY_W-1:0]);
            alu_limit = 32'(end_clip);
        end
        else
        begin
            alu_a     = 32'(idx_reg);
            alu_b     = 32'd1;
            alu_limit = 32'(end_reg);
        end
    end

    assign final_beat = alu_reached || (cnt_reg == CNT_W'(MAX_FANOUT - 1));

    always_comb
    begin
        ctrl            = '0;
        ctrl.gate_raddr = gate[GATE_AW-1:0];
        ctrl.off_raddr  = OFF_AW'(gate);
        ctrl.edge_raddr = idx_reg[EDGE_AW-1:0];
        ctrl.gate_waddr = table_index[GATE_AW-1:0];
        ctrl.gate_wdata = table_word;
        ctrl.off_waddr  = table_index[OFF_AW-1:0];
        ctrl.off_wdata  = table_word[OFF_W-1:0];
        ctrl.edge_waddr = table_index[EDGE_AW-1:0];
        ctrl.edge_wdata = table_word[EDGE_W-1:0];

        state_next = state_reg;
        ts_next    = ts_reg;
        gate_next  = gate_reg;
        port_next  = port_reg;
        value_next = value_reg;
        time_next  = time_reg;
        nw_next    = nw_reg;
        idx_next   = idx_reg;
        end_next   = end_reg;
        cnt_next   = cnt_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (cmd)
                        CMD_EVENT:
                        begin
                            if (32'(gate) < NUM_GATES)
                            begin
                                ctrl.gate_re = 1'b1;
                                ctrl.off_re  = 1'b1;
                                ts_next      = timestamp;
                                gate_next    = gate[GATE_AW-1:0];
                                port_next    = port;
                                value_next   = logic_value;
                                state_next   = ST_EVAL;
                            end
                        end
                        CMD_WR_GATE:
                        begin
                            ctrl.gate_we = (32'(table_index) < NUM_GATES);
                        end
                        CMD_WR_OFFSET:
                        begin
                            ctrl.off_we = (32'(table_index) < NUM_GATES + 1);
                        end
                        CMD_WR_EDGE:
                        begin
                            ctrl.edge_we = (32'(table_index) < NUM_EDGES);
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_EVAL:
            begin
                // Write the updated state back, bit 19 cleared.
                ctrl.gate_we    = 1'b1;
                ctrl.gate_waddr = gate_reg;
                ctrl.gate_wdata = {new_out, in0, in1, 1'b0, rd.gate_word[18:0]};
                ctrl.edge_re    = 1'b1;
                ctrl.edge_raddr = rd.off_start[EDGE_AW-1:0];
                time_next       = alu_sum;
                nw_next         = new_out;
                idx_next        = rd.off_start;
                end_next        = end_clip;
                cnt_next        = '0;
                if ((new_out != cur_out) && (rd.off_start < end_clip))
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_EMIT:
            begin
                // Fetch the next edge while this beat is on the ports.
                ctrl.edge_raddr = alu_sum[EDGE_AW-1:0];
                if (final_beat)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    ctrl.edge_re = 1'b1;
                    idx_next     = alu_sum[OFF_W-1:0];
                    cnt_next     = cnt_reg + CNT_W'(1);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
            end_reg   <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            end_reg   <= end_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ts_reg    <= ts_next;
        gate_reg  <= gate_next;
        port_reg  <= port_next;
        value_reg <= value_next;
        time_reg  <= time_next;
        nw_reg    <= nw_next;
    end

    assign busy          = (state_reg != ST_IDLE);
    assign result_strobe = (state_reg == ST_EMIT);
    assign event_time    = time_reg;
    assign target_gate   = rd.edge_word[10:1];
    assign target_port   = rd.edge_word[0];
    assign event_value   = nw_reg;
    assign last          = (state_reg == ST_EMIT) && final_beat;

endmodule
`default_nettype wire
